### src/jdc_pkg.sv
// jdc_pkg: shared types and constants of the julian day converter
// holds the request record, range limits and reciprocal multipliers
// no dependencies
package jdc_pkg;

	// request fields echoed down the pipeline
	typedef struct packed {
		logic               cmd;
		logic signed [14:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [22:0]        day_number;
	} req_t;

	localparam logic              CMD_TO_JDN  = 1'b0;
	localparam logic              CMD_TO_DATE = 1'b1;

	localparam logic [22:0]        JDN_MAX  = 23'd5373484;
	localparam logic signed [14:0] YEAR_MIN = -15'sd4713;
	localparam logic signed [14:0] YEAR_MAX = 15'sd9999;

	// ceil(c * 2^k / d) reciprocals, k chosen so that xmax * d < 2^k
	localparam logic [14:0] CEN_MUL = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
	localparam logic [24:0] T2_MUL  = 25'(((64'd4 << 40) + 64'd146096) / 64'd146097);
	localparam logic [27:0] YR_MUL  = 28'(((64'd4000 << 36) + 64'd1461000) / 64'd1461001);
	localparam logic [16:0] MO_MUL  = 17'(((64'd80 << 21) + 64'd2446) / 64'd2447);
	localparam logic [23:0] W7_MUL  = 24'(((64'd1 << 26) + 64'd6) / 64'd7);

endpackage

### src/julian_day_converter_core.sv
// julian_day_converter_core: gregorian date <-> julian day number, six stage pipeline
// depends on jdc_pkg
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: year, month, day, day_number; s_tuser: cmd
// m_*       out  m_tvalid / m_tready    m_tdata: jdn, year, month, day, weekday; m_tuser: error
//
// one item per clock while m_tready does not hold the output back
// the depth is set by the chain of reciprocal multiplies on the day number to date path
// each stage holds its item while the stage after it is full and stalled, so a stall ripples back
// s_tready drops only when every stage holds an item and m_tready is low
// arst_n clears the valid bits only; no clearing pass
module julian_day_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // year[14:0], month[18:15], day[23:19], day_number[46:24]
	input  logic [0:0]  s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // jdn[22:0], year[37:23], month[41:38], day[46:42],
	                              // weekday[49:47]
	output logic [0:0]  m_tuser   // range_error[0]
);

	// 367 * m' / 12 by month, m' being month shifted so that march is 1
	localparam logic [8:0] MON_OFF [16] = '{
		9'd0, 9'd336, 9'd367, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152,
		9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd0, 9'd0, 9'd0
	};
	// 2447 * mo / 80
	localparam logic [8:0] MO_OFF [16] = '{
		9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
	};

	logic v1, v2, v3, v4, v5, v6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v6 || m_tready;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign s_tready = en1;
	assign m_tvalid = v6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (en1) v1 <= s_tvalid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
		end
	end

	// stage 1: month offsets, year products, day number offset and product
	jdc_pkg::req_t      req_in;
	logic               early;
	logic signed [15:0] y1_w, y2_w;
	logic [23:0]        t1_w;
	logic               bad0_w;

	assign req_in.cmd        = s_tuser[0];
	assign req_in.year       = s_tdata[14:0];
	assign req_in.month      = s_tdata[18:15];
	assign req_in.day        = s_tdata[23:19];
	assign req_in.day_number = s_tdata[46:24];

	always_comb begin
		early  = (req_in.month <= 4'd2);
		y1_w   = 16'(req_in.year) + 16'sd4800 - (early ? 16'sd1 : 16'sd0);
		y2_w   = 16'(req_in.year) + 16'sd4900 - (early ? 16'sd1 : 16'sd0);
		t1_w   = {1'b0, req_in.day_number} + 24'd68569;
		bad0_w = (req_in.month < 4'd1) || (req_in.month > 4'd12) || (req_in.day == 5'd0) ||
			(req_in.year < jdc_pkg::YEAR_MIN) || (req_in.year > jdc_pkg::YEAR_MAX);
	end

	jdc_pkg::req_t req_s1;
	logic          bad_s1;
	logic [24:0]   amul_s1;
	logic [28:0]   cen_s1;
	logic [8:0]    mtab_s1;
	logic [23:0]   t1_s1;
	logic [48:0]   t2p_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1  <= req_in;
			bad_s1  <= bad0_w;
			amul_s1 <= {11'd0, y1_w[13:0]} * 25'd1461;
			cen_s1  <= {15'd0, y2_w[13:0]} * {14'd0, jdc_pkg::CEN_MUL};
			mtab_s1 <= MON_OFF[req_in.month];
			t1_s1   <= t1_w;
			t2p_s1  <= {25'd0, t1_w} * {24'd0, jdc_pkg::T2_MUL};
		end
	end

	// stage 2: day number sum and range, century remainder
	logic [7:0]         cen_w, cb_w, t2_w;
	logic [9:0]         c3_w;
	logic signed [24:0] j_w;
	logic [25:0]        t2off_w;
	logic               bad1_w;

	always_comb begin
		cen_w   = cen_s1[28:21];
		c3_w    = {2'd0, cen_w} * 10'd3;
		cb_w    = c3_w[9:2];
		j_w     = $signed({20'd0, req_s1.day}) - 25'sd32075 + $signed({2'd0, amul_s1[24:2]})
			+ $signed({16'd0, mtab_s1}) - $signed({17'd0, cb_w});
		bad1_w  = bad_s1 || (j_w < 25'sd0) || (j_w > $signed({2'd0, jdc_pkg::JDN_MAX}));
		t2_w    = t2p_s1[47:40];
		t2off_w = ({18'd0, t2_w} * 26'd146097 + 26'd3) >> 2;
	end

	jdc_pkg::req_t req_s2;
	logic          bad_s2;
	logic [22:0]   j_s2;
	logic [7:0]    t2_s2;
	logic [15:0]   t1p_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			req_s2 <= req_s1;
			bad_s2 <= bad1_w;
			j_s2   <= j_w[22:0];
			t2_s2  <= t2_w;
			t1p_s2 <= 16'({2'd0, t1_s1} - t2off_w);
		end
	end

	// stage 3: weekday and year-in-century products
	logic [22:0] x_w;
	logic [16:0] t1p1_w;

	assign x_w    = (req_s2.cmd == jdc_pkg::CMD_TO_DATE) ? req_s2.day_number : j_s2;
	assign t1p1_w = {1'b0, t1p_s2} + 17'd1;

	jdc_pkg::req_t req_s3;
	logic          bad_s3;
	logic [22:0]   j_s3, x_s3;
	logic [7:0]    t2_s3;
	logic [15:0]   t1p_s3;
	logic [46:0]   w7p_s3;
	logic [44:0]   yrp_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			req_s3 <= req_s2;
			bad_s3 <= bad_s2;
			j_s3   <= j_s2;
			t2_s3  <= t2_s2;
			t1p_s3 <= t1p_s2;
			x_s3   <= x_w;
			w7p_s3 <= {24'd0, x_w} * {23'd0, jdc_pkg::W7_MUL};
			yrp_s3 <= {28'd0, t1p1_w} * {17'd0, jdc_pkg::YR_MUL};
		end
	end

	// stage 4: x mod 7 from the quotient, since -7q = q mod 8; year in century, day in year
	logic [20:0] q7_w;
	logic [7:0]  yr_w;
	logic [19:0] yoff_w;

	always_comb begin
		q7_w   = w7p_s3[46:26];
		yr_w   = yrp_s3[43:36];
		yoff_w = ({12'd0, yr_w} * 20'd1461) >> 2;
	end

	jdc_pkg::req_t req_s4;
	logic          bad_s4;
	logic [22:0]   j_s4;
	logic [7:0]    t2_s4, yr_s4;
	logic [2:0]    wd_s4;
	logic [8:0]    t1pp_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			req_s4  <= req_s3;
			bad_s4  <= bad_s3;
			j_s4    <= j_s3;
			t2_s4   <= t2_s3;
			yr_s4   <= yr_w;
			wd_s4   <= x_s3[2:0] + q7_w[2:0];
			t1pp_s4 <= 9'({4'd0, t1p_s3} - yoff_w + 20'd31);
		end
	end

	// stage 5: month product
	jdc_pkg::req_t req_s5;
	logic          bad_s5;
	logic [22:0]   j_s5;
	logic [7:0]    t2_s5, yr_s5;
	logic [2:0]    wd_s5;
	logic [8:0]    t1pp_s5;
	logic [25:0]   mop_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			req_s5  <= req_s4;
			bad_s5  <= bad_s4;
			j_s5    <= j_s4;
			t2_s5   <= t2_s4;
			yr_s5   <= yr_s4;
			wd_s5   <= wd_s4;
			t1pp_s5 <= t1pp_s4;
			mop_s5  <= {17'd0, t1pp_s4} * {9'd0, jdc_pkg::MO_MUL};
		end
	end

	// stage 6: date assembly and result selection
	logic [4:0]         mo_w, mm_w;
	logic               yc_w;
	logic [8:0]         dd_w;
	logic signed [15:0] yy_w;
	logic               dn_bad_w;
	logic [22:0]        jdn_w;
	logic [14:0]        year_w;
	logic [3:0]         month_w;
	logic [4:0]         day_w;
	logic [2:0]         wd_w;
	logic               err_w;

	always_comb begin
		mo_w     = mop_s5[25:21];
		yc_w     = (mo_w >= 5'd11);
		dd_w     = t1pp_s5 - MO_OFF[mo_w[3:0]];
		mm_w     = mo_w + 5'd2 - (yc_w ? 5'd12 : 5'd0);
		yy_w     = ($signed({8'd0, t2_s5}) - 16'sd49) * 16'sd100
			+ $signed({8'd0, yr_s5}) + $signed({15'd0, yc_w});
		dn_bad_w = (req_s5.day_number > jdc_pkg::JDN_MAX);
		if (req_s5.cmd == jdc_pkg::CMD_TO_JDN) begin
			jdn_w   = bad_s5 ? 23'd0 : j_s5;
			year_w  = req_s5.year;
			month_w = req_s5.month;
			day_w   = req_s5.day;
			wd_w    = bad_s5 ? 3'd0 : wd_s5;
			err_w   = bad_s5;
		end else begin
			jdn_w   = req_s5.day_number;
			year_w  = dn_bad_w ? 15'd0 : yy_w[14:0];
			month_w = dn_bad_w ? 4'd0 : mm_w[3:0];
			day_w   = dn_bad_w ? 5'd0 : dd_w[4:0];
			wd_w    = dn_bad_w ? 3'd0 : wd_s5;
			err_w   = dn_bad_w;
		end
	end

	logic [22:0] jdn_s6;
	logic [14:0] year_s6;
	logic [3:0]  month_s6;
	logic [4:0]  day_s6;
	logic [2:0]  wd_s6;
	logic        err_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			jdn_s6   <= jdn_w;
			year_s6  <= year_w;
			month_s6 <= month_w;
			day_s6   <= day_w;
			wd_s6    <= wd_w;
			err_s6   <= err_w;
		end
	end

	assign m_tdata = {6'd0, wd_s6, day_s6, month_s6, year_s6, jdn_s6};
	assign m_tuser = err_s6;

endmodule

### src/jdc_port_checker.sv
// jdc_port_checker: port-level checks on the julian day converter, bound to the top level
// depends on jdc_pkg and julian_day_converter_core
module jdc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// the input side only backs up when the output is held
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("held result item changed");

	a_err_wday: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[49:47] == 3'd0))
		else $error("flagged item carries a weekday");

	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> ((m_tdata[22:0] <= jdc_pkg::JDN_MAX) &&
		(m_tdata[49:47] <= 3'd6) && (m_tdata[41:38] >= 4'd1) && (m_tdata[41:38] <= 4'd12) &&
		(m_tdata[46:42] != 5'd0)))
		else $error("unflagged item out of range");

endmodule

bind julian_day_converter_core jdc_port_checker u_jdc_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
